// ===== design/esmv_pkg.sv =====
package esmv_pkg;

  // default geometry
  localparam int DefRows  = 256;
  localparam int DefCols  = 256;
  localparam int DefSlots = 16;

  // field widths
  localparam int DataW  = 32;
  localparam int CountW = 9;
  localparam int WidthW = 5;
  localparam int IdxW   = 8;
  localparam int ColW   = 9;

  // column code of an empty slot
  localparam logic [ColW-1:0] ColEmpty = 9'h1FF;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_MULTIPLY = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1,
    REG_ROW_WIDTH = 2'd2
  } cfg_reg_e;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic valid;
  } mac_ctrl_t;

endpackage

// ===== design/esmv_ram.sv =====
module esmv_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/esmv_mac.sv =====
module esmv_mac #(
  parameter int AccW = 70
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  esmv_pkg::mac_ctrl_t     ctrl_i,
  input  logic [31:0]             a_i,
  input  logic [31:0]             b_i,
  output logic                    busy_o,
  output logic [31:0]             result_o
);
  import esmv_pkg::*;

  localparam logic signed [AccW-1:0] MaxA = {{(AccW-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [AccW-1:0] MinA = {{(AccW-32){1'b1}}, 32'h8000_0000};
  localparam logic signed [AccW-1:0] Half = AccW'(17'h08000);

  logic signed [63:0]     prod_q;
  logic                   prod_v_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] shifted;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.valid && !ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
  end

  // exact accumulation of Q32.32 products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // round to nearest, ties upward, then clamp to Q16.16
  always_comb begin
    rnd     = acc_q + Half;
    shifted = rnd >>> 16;
    if (shifted > MaxA) begin
      result_o = 32'h7FFF_FFFF;
    end else if (shifted < MinA) begin
      result_o = 32'h8000_0000;
    end else begin
      result_o = shifted[31:0];
    end
  end

  assign busy_o = prod_v_q;

endmodule

// ===== design/ellpack_sparse_matvec_core.sv =====
// Load, no-op and out-of-range items go from decode straight to the result state;
// insert and multiply first walk up to the W slots in use, and multiply then finishes.
// One item in flight: the next is accepted only after the result has been loaded
// into the output register.
// Reset: asynchronous, active low. After reset the slot column memory is swept to
// empty, during which s_axis_tready stays low.
module ellpack_sparse_matvec_core #(
  parameter int ROWS  = esmv_pkg::DefRows,
  parameter int COLS  = esmv_pkg::DefCols,
  parameter int SLOTS = esmv_pkg::DefSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // row_index[7:0], col_index[15:8], data_value[47:16]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // row_product[31:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import esmv_pkg::*;

  localparam int SlotDepth = ROWS * SLOTS;
  localparam int SaW  = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;
  localparam int VaW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int SlW  = $clog2(SLOTS + 1);
  localparam int AccW = 64 + $clog2(SLOTS) + 1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_WALK   = 6'b001000,
    ST_FIN    = 6'b010000,
    ST_RESULT = 6'b100000
  } state_e;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [CountW-1:0] row_count_q, col_count_q;
  logic [WidthW-1:0] row_width_q;

  // latched item
  cmd_e            cmd_q;
  logic [IdxW-1:0] row_q, col_q;
  logic [31:0]     data_q;

  // walk state
  logic [SaW-1:0] base_q, clr_q, p1_addr_q;
  logic [SlW-1:0] slot_q, width_eff;
  logic           stop_q, found_q, p1_v_q, p2_v_q;
  logic [31:0]    p2_val_q;

  // result and output register
  status_e     res_status_q;
  logic [31:0] res_product_q;
  logic        out_valid_q;
  status_e     out_status_q;
  logic [31:0] out_product_q;

  // memory ports
  logic [ColW-1:0] col_rd;
  logic [31:0]     val_rd, vec_rd;
  logic            colm_we, vec_we;
  logic [SaW-1:0]  colm_waddr, slot_raddr;
  logic [ColW-1:0] colm_wdata;
  logic [31:0]     valm_wdata;

  // control
  logic      in_acc, row_ok, col_ok, issue, p1_live, col_empty, col_hit;
  logic      ins_wr, mul_adv, mul_stop, drained, out_load, mac_busy;
  logic [31:0] mac_result;
  mac_ctrl_t mac_ctrl;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // range checks against the registers and the sizes built in
  assign row_ok = (CountW'(row_q) < row_count_q) && (int'(row_q) < ROWS);
  assign col_ok = (CountW'(col_q) < col_count_q) && (int'(col_q) < COLS);
  assign width_eff = (int'(row_width_q) < SLOTS) ? SlW'(row_width_q) : SlW'(SLOTS);

  // row walk: one slot read issued per cycle, checked the cycle after
  assign issue     = (state_q == ST_WALK) && (slot_q < width_eff) && !stop_q;
  assign slot_raddr = base_q + SaW'(slot_q);
  assign p1_live   = p1_v_q && !stop_q;
  assign col_empty = (col_rd == ColEmpty);
  assign col_hit   = (col_rd == ColW'(col_q));
  assign ins_wr    = (state_q == ST_WALK) && (cmd_q == CMD_INSERT) && p1_live &&
                     (col_empty || col_hit);
  assign mul_adv   = (state_q == ST_WALK) && (cmd_q == CMD_MULTIPLY) && p1_live && !col_empty;
  assign mul_stop  = (state_q == ST_WALK) && (cmd_q == CMD_MULTIPLY) && p1_live && col_empty;
  assign drained   = !issue && !p1_v_q && !p2_v_q && !mac_busy;

  // memory write muxing: the sweep after reset, then inserts
  assign colm_we    = (state_q == ST_CLEAR) || ins_wr;
  assign colm_waddr = (state_q == ST_CLEAR) ? clr_q : p1_addr_q;
  assign colm_wdata = (state_q == ST_CLEAR) ? ColEmpty : ColW'(col_q);
  assign valm_wdata = col_empty ? data_q : sat_add32(val_rd, data_q);
  assign vec_we     = (state_q == ST_DECODE) && (cmd_q == CMD_LOAD) && col_ok;

  esmv_ram #(.Width(ColW), .Depth(SlotDepth)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (colm_we),
    .waddr_i (colm_waddr),
    .wdata_i (colm_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (col_rd)
  );

  esmv_ram #(.Width(DataW), .Depth(SlotDepth)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ins_wr),
    .waddr_i (p1_addr_q),
    .wdata_i (valm_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (val_rd)
  );

  esmv_ram #(.Width(DataW), .Depth(COLS)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (VaW'(col_q)),
    .wdata_i (data_q),
    .raddr_i (VaW'(col_rd)),
    .rdata_o (vec_rd)
  );

  assign mac_ctrl.clr   = (state_q == ST_DECODE);
  assign mac_ctrl.valid = p2_v_q;

  esmv_mac #(.AccW(AccW)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (vec_rd),
    .b_i      (p2_val_q),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // sequencer
  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == SaW'(SlotDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (cmd_q)
          CMD_INSERT:   state_d = (row_ok && col_ok) ? ST_WALK : ST_RESULT;
          CMD_MULTIPLY: state_d = row_ok ? ST_WALK : ST_RESULT;
          default:      state_d = ST_RESULT;
        endcase
      end
      ST_WALK: begin
        if (drained) state_d = (cmd_q == CMD_MULTIPLY) ? ST_FIN : ST_RESULT;
      end
      ST_FIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      row_count_q <= CountW'(256);
      col_count_q <= CountW'(256);
      row_width_q <= WidthW'(16);
      slot_q      <= '0;
      stop_q      <= 1'b0;
      found_q     <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + SaW'(1);
      // register writes; an index beyond the list is ignored
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ROW_COUNT) row_count_q <= cfg_data_i;
        if (cfg_index_i == REG_COL_COUNT) col_count_q <= cfg_data_i;
        if (cfg_index_i == REG_ROW_WIDTH) row_width_q <= cfg_data_i[WidthW-1:0];
      end
      // walk bookkeeping
      if (state_q == ST_DECODE) begin
        slot_q  <= '0;
        stop_q  <= 1'b0;
        found_q <= 1'b0;
      end else begin
        if (issue) slot_q <= slot_q + SlW'(1);
        if (ins_wr || mul_stop) stop_q <= 1'b1;
        if (ins_wr) found_q <= 1'b1;
      end
      p1_v_q <= issue;
      p2_v_q <= mul_adv;
      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_e'(s_axis_tuser);
      row_q  <= s_axis_tdata[7:0];
      col_q  <= s_axis_tdata[15:8];
      data_q <= s_axis_tdata[47:16];
    end
    if (state_q == ST_DECODE) begin
      base_q        <= SaW'(int'(row_q) * SLOTS);
      res_product_q <= '0;
      unique case (cmd_q)
        CMD_LOAD:     res_status_q <= col_ok ? STAT_OK : STAT_RANGE;
        CMD_INSERT:   res_status_q <= (row_ok && col_ok) ? STAT_OK : STAT_RANGE;
        CMD_MULTIPLY: res_status_q <= row_ok ? STAT_OK : STAT_RANGE;
        default:      res_status_q <= STAT_OK;
      endcase
    end
    if ((state_q == ST_WALK) && drained && (cmd_q == CMD_INSERT)) begin
      res_status_q <= found_q ? STAT_OK : STAT_FULL;
    end
    if (state_q == ST_FIN) begin
      res_product_q <= mac_result;
    end
    p1_addr_q <= slot_raddr;
    p2_val_q  <= val_rd;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_product_q <= res_product_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_product_q;
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTHESIS
  // slot pipeline only carries data while a row is being walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_v_q |-> state_q == ST_WALK)
    else $error("slot read in flight outside a row walk");

  // a full row can only come from an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) && (res_status_q == STAT_FULL) |-> cmd_q == CMD_INSERT)
    else $error("row full reported for a non-insert item");

  // a non-zero product only from a successful multiply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) && (res_product_q != '0) |->
      (cmd_q == CMD_MULTIPLY) && (res_status_q == STAT_OK))
    else $error("non-zero product for a non-multiply item");

  // the walk never runs past the slots in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> slot_q <= width_eff)
    else $error("slot counter beyond row width");

  // an insert write ends the walk with success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_wr |=> found_q && stop_q)
    else $error("insert write not recorded");
`endif

endmodule

// ===== dv/tb_ellpack_sparse_matvec_core.sv =====
module tb_ellpack_sparse_matvec_core;
  import esmv_pkg::*;

  localparam int NRows       = DefRows;
  localparam int NCols       = DefCols;
  localparam int NSlots      = DefSlots;
  localparam int RandomItems = 800;
  localparam int HoldCycles  = 400;
  localparam int NumPhases   = 9;

  // fixed register settings for the first random phases, extremes included
  localparam logic [CountW-1:0] PhaseRows [NumPhases] = '{
    9'd256, 9'd1, 9'd16, 9'd511, 9'd8, 9'd0, 9'd256, 9'd6, 9'd200};
  localparam logic [CountW-1:0] PhaseCols [NumPhases] = '{
    9'd256, 9'd1, 9'd24, 9'd511, 9'd12, 9'd256, 9'd0, 9'd40, 9'd256};
  localparam logic [WidthW-1:0] PhaseWidth [NumPhases] = '{
    5'd16, 5'd1, 5'd4, 5'd31, 5'd16, 5'd16, 5'd16, 5'd0, 5'd8};

  typedef struct {
    cmd_e             cmd;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [DataW-1:0] value;
  } command_item_t;

  typedef struct {
    status_e          status;
    logic [DataW-1:0] product;
  } answer_t;

  // mirror of the matrix, the vector and the registers; predicts each answer
  class ellpack_mirror;
    logic [ColW-1:0]   slot_col [NRows*NSlots];
    logic [DataW-1:0]  slot_val [NRows*NSlots];
    logic [DataW-1:0]  x_val [NCols];
    bit                x_loaded [NCols];
    logic [CountW-1:0] rows_reg;
    logic [CountW-1:0] cols_reg;
    logic [WidthW-1:0] width_reg;
    answer_t           answers_due [$];
    int unsigned       mismatch_count;
    int unsigned       answers_seen;

    function new();
      foreach (slot_col[k]) slot_col[k] = ColEmpty;
      foreach (x_loaded[c]) x_loaded[c] = 1'b0;
      rows_reg       = 9'd256;
      cols_reg       = 9'd256;
      width_reg      = 5'd16;
      mismatch_count = 0;
      answers_seen   = 0;
    endfunction

    function int unsigned rows_in_use();
      return (rows_reg < NRows) ? rows_reg : NRows;
    endfunction

    function int unsigned cols_in_use();
      return (cols_reg < NCols) ? cols_reg : NCols;
    endfunction

    function int unsigned width_in_use();
      return (width_reg < NSlots) ? width_reg : NSlots;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CountW-1:0] val);
      case (idx)
        REG_ROW_COUNT: rows_reg = val;
        REG_COL_COUNT: cols_reg = val;
        REG_ROW_WIDTH: width_reg = val[WidthW-1:0];
        default: ;
      endcase
    endfunction

    // column in the row walk whose vector element was never loaded, or -1
    function int first_unloaded(int unsigned row);
      int unsigned k;
      for (int s = 0; s < width_in_use(); s++) begin
        k = row * NSlots + s;
        if (slot_col[k] == ColEmpty) break;
        if (!x_loaded[slot_col[k][IdxW-1:0]]) return int'(slot_col[k]);
      end
      return -1;
    endfunction

    function logic [DataW-1:0] sat_q16(logic signed [79:0] v);
      if (v > 80'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -80'sh8000_0000) return 32'h8000_0000;
      return v[DataW-1:0];
    endfunction

    // exact sum of Q32.32 products, rounded half up to Q16.16, then saturated
    function logic [DataW-1:0] row_dot(int unsigned row);
      logic signed [79:0] acc;
      logic signed [63:0] prod;
      int unsigned k;
      acc = '0;
      for (int s = 0; s < width_in_use(); s++) begin
        k = row * NSlots + s;
        if (slot_col[k] == ColEmpty) break;
        prod = $signed(x_val[slot_col[k][IdxW-1:0]]) * $signed(slot_val[k]);
        acc += 80'(prod);
      end
      acc = (acc + 80'sh8000) >>> 16;
      return sat_q16(acc);
    endfunction

    function void apply_command(command_item_t it);
      answer_t ans;
      int unsigned k;
      logic signed [DataW:0] sum;
      ans.status  = STAT_OK;
      ans.product = '0;
      case (it.cmd)
        CMD_LOAD: begin
          if (it.col < cols_in_use()) begin
            x_val[it.col]    = it.value;
            x_loaded[it.col] = 1'b1;
          end else begin
            ans.status = STAT_RANGE;
          end
        end
        CMD_INSERT: begin
          if (it.row >= rows_in_use() || it.col >= cols_in_use()) begin
            ans.status = STAT_RANGE;
          end else begin
            ans.status = STAT_FULL;
            for (int s = 0; s < width_in_use(); s++) begin
              k = it.row * NSlots + s;
              if (slot_col[k] == ColEmpty) begin
                slot_col[k] = ColW'(it.col);
                slot_val[k] = it.value;
                ans.status  = STAT_OK;
                break;
              end
              // same column again: accumulate with saturation
              if (slot_col[k] == it.col) begin
                sum         = $signed(slot_val[k]) + $signed(it.value);
                slot_val[k] = sat_q16(sum);
                ans.status  = STAT_OK;
                break;
              end
            end
          end
        end
        CMD_MULTIPLY: begin
          if (it.row >= rows_in_use()) ans.status = STAT_RANGE;
          else ans.product = row_dot(it.row);
        end
        default: ;
      endcase
      answers_due = {answers_due, ans};
    endfunction

    task flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      $display("mismatch on result %0d, %s: expected %h, got %h",
               answers_seen, what, want, got);
    endtask

    task match_answer(logic [1:0] status, logic [DataW-1:0] product);
      answer_t want;
      answers_seen++;
      if (answers_due.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, product);
        return;
      end
      want = answers_due.pop_front();
      if (status !== want.status) flag_mismatch("status", 32'(want.status), 32'(status));
      if (product !== want.product) flag_mismatch("row_product", want.product, product);
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [CountW-1:0] cfg_data_i;

  ellpack_mirror mirror = new();
  int unsigned   burst_left = 0;

  ellpack_sparse_matvec_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results are checked as they are taken
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready)
      mirror.match_answer(m_axis_tuser, m_axis_tdata);
  end

  // result side: changing stall patterns, plus a few long hold-offs
  initial begin
    int unsigned mode;
    int unsigned tick;
    int unsigned next_hold;
    m_axis_tready = 1'b0;
    mode          = 0;
    tick          = 0;
    next_hold     = 120;
    forever begin
      @(negedge clk);
      if (mirror.answers_seen >= next_hold) begin
        // hold off long enough for the core to back up into its input
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        next_hold += 350;
      end
      if (tick % 50 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready <= (tick % 3 == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic command_item_t item_of(cmd_e c, int unsigned r, int unsigned col,
                                            logic [DataW-1:0] v);
    command_item_t it;
    it.cmd   = c;
    it.row   = r[IdxW-1:0];
    it.col   = col[IdxW-1:0];
    it.value = v;
    return it;
  endfunction

  // a multiply must never reach a vector element that was never loaded
  function automatic command_item_t keep_reads_defined(command_item_t it);
    int c;
    if (it.cmd != CMD_MULTIPLY || it.row >= mirror.rows_in_use()) return it;
    c = mirror.first_unloaded(it.row);
    if (c < 0) return it;
    it.cmd = CMD_LOAD;
    if (c < mirror.cols_in_use()) it.col = c[IdxW-1:0];
    return it;
  endfunction

  // mostly a few hot indices so rows fill up and columns repeat
  function automatic logic [IdxW-1:0] pick_index(int unsigned in_use, int unsigned hot);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (in_use == 0 || roll < 10) return IdxW'($urandom_range(0, 255));
    if (roll < 60) return IdxW'($urandom_range(0, ((in_use < hot) ? in_use : hot) - 1));
    if (roll < 70) return IdxW'(in_use - 1);
    return IdxW'($urandom_range(0, in_use - 1));
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom();
    // small magnitudes, within +-4.0
    if (roll < 80) return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic command_item_t random_item();
    command_item_t it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) it.cmd = CMD_LOAD;
    else if (roll < 62) it.cmd = CMD_INSERT;
    else if (roll < 95) it.cmd = CMD_MULTIPLY;
    else it.cmd = CMD_NOP;
    it.row   = pick_index(mirror.rows_in_use(), 6);
    it.col   = pick_index(mirror.cols_in_use(), 10);
    it.value = pick_value();
    return it;
  endfunction

  function automatic logic [CountW-1:0] random_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      case ($urandom_range(0, 3))
        0:       return 9'd0;
        1:       return 9'd1;
        2:       return 9'd256;
        default: return 9'd511;
      endcase
    end
    if (roll < 40) return CountW'($urandom_range(1, 256));
    return CountW'($urandom_range(1, 64));
  endfunction

  function automatic logic [WidthW-1:0] random_width();
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 5'd0;
        1:       return 5'd1;
        2:       return 5'd16;
        default: return 5'd31;
      endcase
    end
    return WidthW'($urandom_range(1, 16));
  endfunction

  // offer one item in bursts with random gaps; entered and left at a falling edge
  task automatic send_item(command_item_t it);
    int unsigned gap;
    it = keep_reads_defined(it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {it.value, it.col, it.row};
    do @(posedge clk); while (!s_axis_tready);
    mirror.apply_command(it);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CountW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    mirror.set_register(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [CountW-1:0] rows, logic [CountW-1:0] cols,
                                logic [WidthW-1:0] width);
    write_register(REG_ROW_COUNT, rows);
    write_register(REG_COL_COUNT, cols);
    write_register(REG_ROW_WIDTH, {4'b0, width});
    cfg_valid_i <= 1'b0;
  endtask

  // drain every pending answer, then let the core go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (mirror.answers_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    burst_left = 0;
  endtask

  initial begin
    command_item_t it;
    int unsigned   sent;
    int unsigned   phase;
    int unsigned   quota;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_NOP;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ROW_COUNT;
    cfg_data_i    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, saturation both ways, duplicate columns, rounding ties
    send_item(item_of(CMD_LOAD, 0, 0, 32'h7FFF_FFFF));
    send_item(item_of(CMD_LOAD, 0, 255, 32'h8000_0000));
    send_item(item_of(CMD_LOAD, 0, 1, 32'h0001_0000));
    send_item(item_of(CMD_LOAD, 0, 2, 32'hFFFF_8000));
    send_item(item_of(CMD_INSERT, 0, 0, 32'h7FFF_FFFF));
    send_item(item_of(CMD_INSERT, 0, 255, 32'h8000_0000));
    send_item(item_of(CMD_MULTIPLY, 0, 0, 32'h0));
    send_item(item_of(CMD_INSERT, 254, 255, 32'h7FFF_FFFF));
    send_item(item_of(CMD_MULTIPLY, 254, 0, 32'h0));
    send_item(item_of(CMD_INSERT, 1, 1, 32'h7FFF_0000));
    send_item(item_of(CMD_INSERT, 1, 1, 32'h7FFF_0000));
    send_item(item_of(CMD_INSERT, 1, 2, 32'h8000_0000));
    send_item(item_of(CMD_INSERT, 1, 2, 32'h8000_0000));
    send_item(item_of(CMD_MULTIPLY, 1, 0, 32'h0));
    send_item(item_of(CMD_INSERT, 2, 2, 32'hFFFF_FFFF));
    send_item(item_of(CMD_MULTIPLY, 2, 0, 32'h0));
    send_item(item_of(CMD_INSERT, 3, 2, 32'h0000_0001));
    send_item(item_of(CMD_MULTIPLY, 3, 0, 32'h0));
    send_item(item_of(CMD_MULTIPLY, 200, 0, 32'h0));
    send_item(item_of(CMD_NOP, 255, 255, 32'hA5A5_5A5A));
    settle();

    // out of range, full row, and a shrunken row width
    apply_settings(9'd4, 9'd3, 5'd1);
    send_item(item_of(CMD_LOAD, 0, 3, 32'h1234_5678));
    send_item(item_of(CMD_INSERT, 4, 0, 32'h0001_0000));
    send_item(item_of(CMD_INSERT, 0, 1, 32'h0001_0000));
    send_item(item_of(CMD_MULTIPLY, 0, 0, 32'h0));
    send_item(item_of(CMD_MULTIPLY, 4, 0, 32'h0));
    settle();

    // zero row width: every row is full and every walk is empty
    apply_settings(9'd2, 9'd256, 5'd0);
    send_item(item_of(CMD_INSERT, 1, 5, 32'h0002_0000));
    send_item(item_of(CMD_MULTIPLY, 1, 0, 32'h0));
    settle();

    // random phases, each under its own register setting
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      if (phase < NumPhases)
        apply_settings(PhaseRows[phase], PhaseCols[phase], PhaseWidth[phase]);
      else
        apply_settings(random_count(), random_count(), random_width());
      quota = $urandom_range(50, 110);
      repeat (quota) begin
        it = random_item();
        send_item(it);
        if (it.cmd != CMD_NOP) sent++;
      end
      settle();
      phase++;
    end

    repeat (40) @(negedge clk);
    if (mirror.mismatch_count == 0 && mirror.answers_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/esmv_pkg.sv
design/esmv_ram.sv
design/esmv_mac.sv
design/ellpack_sparse_matvec_core.sv
dv/tb_ellpack_sparse_matvec_core.sv
